// ----- hdl/tbd_pkg.sv -----
package tbd_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 16;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int SIZE_REG_W  = 11;
  localparam int RAD_REG_W   = 5;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RADIUS       = 2'd2;

  localparam logic [SIZE_REG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [SIZE_REG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [RAD_REG_W-1:0]  RST_RADIUS       = 5'd4;

  typedef logic [23:0] pixel_t;

  localparam pixel_t     WHITE_PIX = 24'hFFFFFF;
  localparam logic [7:0] GRAY_BYTE = 8'd128;

endpackage

// ----- hdl/trimap_border_dilation_top.sv -----
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | action, in_chan0..2
// out     | output    | out_valid/out_stall| out_chan0..2, in_unknown_band, frame_last
// cfg     | input     | cfg_write          | cfg_index, cfg_data
//
// A pixel that releases a result keeps in_stall high through its disk scan and while its result
// waits under out_stall: the disk scan reads one border bit per cycle from the single border RAM
// port and stops at the first hit.
// Items without a result keep in_stall high while up to five neighbor reads run on the pixel
// RAM port.
// Reset (rst, synchronous) restores the register defaults and clears the stream counters;
// the line stores are not cleared. The block takes the next item while a result waits
// under out_stall, and holds that item's result until the output register is free.
module trimap_border_dilation_top
  import tbd_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [7:0]                     in_chan0,
  input  logic [7:0]                     in_chan1,
  input  logic [7:0]                     in_chan2,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_chan0,
  output logic [7:0]                     out_chan1,
  output logic [7:0]                     out_chan2,
  output logic                           in_unknown_band,
  output logic                           frame_last,
  input  logic                           cfg_write,
  input  logic [tbd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int PIX_ROWS = MAX_RADIUS + 3;
  localparam int BRD_ROWS = 2 * MAX_RADIUS + 2;
  localparam int PIX_DEPTH = PIX_ROWS * MAX_WIDTH;
  localparam int BRD_DEPTH = BRD_ROWS * MAX_WIDTH;
  localparam int PAW = $clog2(PIX_DEPTH > 1 ? PIX_DEPTH : 2);
  localparam int BAW = $clog2(BRD_DEPTH > 1 ? BRD_DEPTH : 2);
  localparam int W_W = $clog2(MAX_WIDTH + 1);
  localparam int H_W = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + MAX_RADIUS + 3);
  localparam int RADW = $clog2(MAX_RADIUS + 2);
  localparam int DW  = RADW + 1;
  localparam int SQW = 2 * DW + 1;
  localparam int P_W = $clog2(MAX_WIDTH * (MAX_HEIGHT + MAX_RADIUS + 2) + MAX_RADIUS + 2);
  localparam int PRW = $clog2(PIX_ROWS);
  localparam int BRW = $clog2(BRD_ROWS);
  localparam int BSW = BRW + 2;
  localparam int YW  = RW + 2;
  localparam int XW  = W_W + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_DECIDE, S_TAP_ADDR, S_TAP_CHK, S_BRD_WR, S_POST,
    S_PIX_RD, S_SCAN_INIT, S_SCAN, S_SCAN_END, S_FINISH
  } state_t;

  state_t state;

  logic [SIZE_REG_W-1:0] fw_reg, fh_reg;
  logic [RAD_REG_W-1:0]  rad_reg;
  logic [W_W-1:0]  w_c;
  logic [H_W-1:0]  h_c;
  logic [RADW-1:0] rad_c;
  logic [P_W-1:0]  n_r, lag_r;

  logic [P_W-1:0] pos;
  logic [W_W-1:0] in_col, qc;
  logic [RW-1:0]  in_row, qr;
  logic [PRW-1:0] pring, qpring;
  logic [BRW-1:0] bring, qbrd;

  logic   act;
  pixel_t pix_in, qval;
  logic [2:0] tap;
  logic   cwhite, nbdark;
  logic signed [DW-1:0] dy, dx;
  logic   ok_d, found;
  logic   out_load;

  logic            pix_en, pix_we;
  logic [PAW-1:0]  pix_addr;
  pixel_t          pix_rdata;
  logic            brd_en, brd_we, brd_wdata;
  logic [BAW-1:0]  brd_addr;
  logic            brd_rdata;

  function automatic logic [PRW-1:0] pdec(input logic [PRW-1:0] x);
    return (x == '0) ? PRW'(PIX_ROWS - 1) : x - PRW'(1);
  endfunction
  function automatic logic [PRW-1:0] pinc(input logic [PRW-1:0] x);
    return (x == PRW'(PIX_ROWS - 1)) ? '0 : x + PRW'(1);
  endfunction
  function automatic logic [BRW-1:0] binc(input logic [BRW-1:0] x);
    return (x == BRW'(BRD_ROWS - 1)) ? '0 : x + BRW'(1);
  endfunction
  function automatic logic [BRW-1:0] bdec(input logic [BRW-1:0] x);
    return (x == '0) ? BRW'(BRD_ROWS - 1) : x - BRW'(1);
  endfunction
  function automatic logic [PAW-1:0] paddr(input logic [PRW-1:0] r, input logic [W_W-1:0] c);
    return PAW'(r) * PAW'(MAX_WIDTH) + PAW'(c);
  endfunction

  // clamp sizes to the supported range
  always_comb begin
    if (fw_reg == '0) w_c = W_W'(1);
    else if (32'(fw_reg) > MAX_WIDTH) w_c = W_W'(MAX_WIDTH);
    else w_c = W_W'(fw_reg);
    if (fh_reg == '0) h_c = H_W'(1);
    else if (32'(fh_reg) > MAX_HEIGHT) h_c = H_W'(MAX_HEIGHT);
    else h_c = H_W'(fh_reg);
    if (32'(rad_reg) > MAX_RADIUS) rad_c = RADW'(MAX_RADIUS);
    else rad_c = RADW'(rad_reg);
  end

  // neighbor taps for the border test
  logic [PRW-1:0] tap_row;
  logic [W_W-1:0] tap_col;
  logic           tap_cond;
  always_comb begin
    tap_row  = pdec(pring);
    tap_col  = in_col;
    tap_cond = 1'b1;
    case (tap)
      3'd1: begin
        tap_row  = pdec(pdec(pring));
        tap_cond = in_row >= RW'(2);
      end
      3'd2: begin
        tap_col  = in_col + W_W'(1);
        tap_cond = (in_col + W_W'(1)) < w_c;
      end
      3'd3: begin
        tap_row  = pring;
        tap_cond = in_row < RW'(h_c);
      end
      3'd4: begin
        tap_col  = in_col - W_W'(1);
        tap_cond = in_col != '0;
      end
      default: ;
    endcase
  end

  // disk scan tap: bounds, disk test and ring address
  logic [YW-1:0]  yy;
  logic [XW-1:0]  xx;
  logic [BSW-1:0] rsum, rrow;
  logic [SQW-1:0] sq, lim;
  logic           scan_ok, scan_last;
  always_comb begin
    yy   = YW'(qr) + YW'(dy);
    xx   = XW'(qc) + XW'(dx);
    sq   = SQW'(dx * dx) + SQW'(dy * dy);
    lim  = SQW'(rad_c) * SQW'(rad_c);
    rsum = BSW'(qbrd) + BSW'(dy);
    if (rsum[BSW-1]) rrow = rsum + BSW'(BRD_ROWS);
    else if (rsum >= BSW'(BRD_ROWS)) rrow = rsum - BSW'(BRD_ROWS);
    else rrow = rsum;
    scan_ok = !yy[YW-1] && (yy < YW'(h_c)) && !xx[XW-1] && (xx < XW'(w_c)) && (sq <= lim);
    scan_last = (dy == DW'(rad_c)) && (dx == DW'(rad_c));
  end

  always_comb begin
    pix_en   = 1'b0;
    pix_we   = 1'b0;
    pix_addr = paddr(tap_row, tap_col);
    brd_en   = 1'b0;
    brd_we   = 1'b0;
    brd_wdata = cwhite && nbdark;
    brd_addr = BAW'(bdec(bring)) * BAW'(MAX_WIDTH) + BAW'(in_col);
    unique case (state)
      S_DECIDE: begin
        pix_en   = (pos < n_r) && !act;
        pix_we   = 1'b1;
        pix_addr = paddr(pring, in_col);
      end
      S_TAP_ADDR: pix_en = tap_cond;
      S_BRD_WR: begin
        brd_en = 1'b1;
        brd_we = 1'b1;
      end
      S_PIX_RD: begin
        pix_en   = 1'b1;
        pix_addr = paddr(qpring, qc);
      end
      S_SCAN: begin
        brd_en   = !(ok_d && brd_rdata);
        brd_addr = BAW'(rrow) * BAW'(MAX_WIDTH) + BAW'(xx);
      end
      default: ;
    endcase
  end

  tbd_ram #(.WIDTH(24), .DEPTH(PIX_DEPTH)) u_pix_ram (
    .clk(clk), .en(pix_en), .we(pix_we), .addr(pix_addr),
    .wdata(pix_in), .rdata(pix_rdata)
  );

  tbd_ram #(.WIDTH(1), .DEPTH(BRD_DEPTH)) u_brd_ram (
    .clk(clk), .en(brd_en), .we(brd_we), .addr(brd_addr),
    .wdata(brd_wdata), .rdata(brd_rdata)
  );

  assign in_stall = state != S_IDLE;
  assign out_load = (state == S_FINISH) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    n_r   <= P_W'(w_c) * P_W'(h_c);
    lag_r <= (P_W'(rad_c) + P_W'(1)) * P_W'(w_c) + P_W'(rad_c) + P_W'(1);
    if (rst) begin
      state     <= S_IDLE;
      fw_reg    <= RST_FRAME_WIDTH;
      fh_reg    <= RST_FRAME_HEIGHT;
      rad_reg   <= RST_RADIUS;
      pos       <= '0;
      in_col    <= '0;
      in_row    <= '0;
      pring     <= '0;
      bring     <= '0;
      qc        <= '0;
      qr        <= '0;
      qpring    <= '0;
      qbrd      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  fw_reg  <= cfg_data;
          REG_FRAME_HEIGHT: fh_reg  <= cfg_data;
          REG_RADIUS:       rad_reg <= cfg_data[RAD_REG_W-1:0];
          default: ;
        endcase
        // any write restarts the frame
        pos    <= '0;
        in_col <= '0;
        in_row <= '0;
        pring  <= '0;
        bring  <= '0;
        qc     <= '0;
        qr     <= '0;
        qpring <= '0;
        qbrd   <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act    <= action;
            pix_in <= {in_chan2, in_chan1, in_chan0};
            state  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          tap    <= '0;
          nbdark <= 1'b0;
          cwhite <= 1'b0;
          if ((pos < n_r) && act) state <= S_IDLE;
          else if ((in_row != '0) && (in_row <= RW'(h_c))) state <= S_TAP_ADDR;
          else state <= S_POST;
        end
        S_TAP_ADDR: begin
          if (tap_cond) state <= S_TAP_CHK;
          else if (tap == 3'd4) state <= S_BRD_WR;
          else tap <= tap + 3'd1;
        end
        S_TAP_CHK: begin
          if (tap == 3'd0) cwhite <= pix_rdata == WHITE_PIX;
          else if (pix_rdata != WHITE_PIX) nbdark <= 1'b1;
          if (tap == 3'd4 || (tap == 3'd0 && pix_rdata != WHITE_PIX)) begin
            state <= S_BRD_WR;
          end else begin
            tap   <= tap + 3'd1;
            state <= S_TAP_ADDR;
          end
        end
        S_BRD_WR: state <= S_POST;
        S_POST: begin
          pos <= pos + P_W'(1);
          if (in_col == w_c - W_W'(1)) begin
            in_col <= '0;
            in_row <= in_row + RW'(1);
            pring  <= pinc(pring);
            bring  <= binc(bring);
          end else begin
            in_col <= in_col + W_W'(1);
          end
          if ((pos >= lag_r) && (qr < RW'(h_c))) state <= S_PIX_RD;
          else state <= S_IDLE;
        end
        S_PIX_RD: state <= S_SCAN_INIT;
        S_SCAN_INIT: begin
          qval  <= pix_rdata;
          dy    <= -DW'(rad_c);
          dx    <= -DW'(rad_c);
          ok_d  <= 1'b0;
          found <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (ok_d && brd_rdata) begin
            found <= 1'b1;
            state <= S_FINISH;
          end else begin
            ok_d <= scan_ok;
            if (scan_last) begin
              state <= S_SCAN_END;
            end else if (dx == DW'(rad_c)) begin
              dx <= -DW'(rad_c);
              dy <= dy + DW'(1);
            end else begin
              dx <= dx + DW'(1);
            end
          end
        end
        S_SCAN_END: begin
          found <= ok_d && brd_rdata;
          state <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (out_load) begin
            out_chan0       <= found ? GRAY_BYTE : qval[7:0];
            out_chan1       <= found ? GRAY_BYTE : qval[15:8];
            out_chan2       <= found ? GRAY_BYTE : qval[23:16];
            in_unknown_band <= found;
            state           <= S_IDLE;
            if ((qr == RW'(h_c) - RW'(1)) && (qc == w_c - W_W'(1))) begin
              frame_last <= 1'b1;
              pos    <= '0;
              in_col <= '0;
              in_row <= '0;
              pring  <= '0;
              bring  <= '0;
              qc     <= '0;
              qr     <= '0;
              qpring <= '0;
              qbrd   <= '0;
            end else begin
              frame_last <= 1'b0;
              if (qc == w_c - W_W'(1)) begin
                qc     <= '0;
                qr     <= qr + RW'(1);
                qpring <= pinc(qpring);
                qbrd   <= binc(qbrd);
              end else begin
                qc <= qc + W_W'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_scan_row_in_frame: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> qr < RW'(h_c))
    else $error("scan on a row beyond the frame");

  a_band_is_gray: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_unknown_band |-> out_chan0 == GRAY_BYTE && out_chan1 == GRAY_BYTE
      && out_chan2 == GRAY_BYTE)
    else $error("band pixel not gray");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_chan0) && $stable(frame_last))
    else $error("stalled result changed");

  a_finish_waits: assert property (@(posedge clk) disable iff (rst)
    state == S_FINISH && out_valid && out_stall |=> state == S_FINISH)
    else $error("result overwrote a waiting one");
`endif

endmodule

// ----- hdl/tbd_ram.sv -----
module tbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule
